// ===== hdl/dq_pkg.sv =====
// Shared types, constants and index helpers for the double-ended queue.
// No dependencies; dq_seq and double_ended_queue_top import this package.
`timescale 1ns / 1ps

package dq_pkg;

  localparam int DEPTH      = 16;
  localparam int ELEM_WIDTH = 32;
  localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int SUM_W      = CNT_W + 1;

  // Request codes
  localparam logic [2:0] REQ_PUSH_FRONT = 3'd0;
  localparam logic [2:0] REQ_PUSH_BACK  = 3'd1;
  localparam logic [2:0] REQ_POP_FRONT  = 3'd2;
  localparam logic [2:0] REQ_POP_BACK   = 3'd3;
  localparam logic [2:0] REQ_STATUS     = 3'd4;

  // Error codes
  localparam logic [1:0] ERR_OK         = 2'd0;
  localparam logic [1:0] ERR_POP_EMPTY  = 2'd1;
  localparam logic [1:0] ERR_PUSH_FULL  = 2'd2;

  typedef logic [ADDR_W-1:0]     addr_t;
  typedef logic [CNT_W-1:0]      cnt_t;
  typedef logic [ELEM_WIDTH-1:0] elem_t;

  // One result as handed from the sequencer to the output register
  typedef struct packed {
    elem_t      popped;
    elem_t      front;
    elem_t      back;
    cnt_t       count;
    logic [1:0] err;
  } res_t;

  // Sequencer status toward the top level
  typedef struct packed {
    logic busy;
    logic res_load;
  } seq_stat_t;

  // Ring index plus offset; both operands stay below DEPTH, so one correction
  function automatic addr_t wrap_add(addr_t a, cnt_t b);
    logic [SUM_W-1:0] s;
    s = SUM_W'(a) + SUM_W'(b);
    if (s >= SUM_W'(DEPTH)) s = s - SUM_W'(DEPTH);
    return s[ADDR_W-1:0];
  endfunction

  function automatic addr_t wrap_inc(addr_t a);
    return (a == addr_t'(DEPTH - 1)) ? '0 : addr_t'(a + 1'b1);
  endfunction

  function automatic addr_t wrap_dec(addr_t a);
    return (a == '0) ? addr_t'(DEPTH - 1) : addr_t'(a - 1'b1);
  endfunction

endpackage

// ===== hdl/dq_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module dq_ram #(
  parameter int DATA_W = 32,
  parameter int WORDS  = 16,
  parameter int ADDR_W = 4
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [WORDS];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  // Read port with registered read data
  always_ff @(posedge clk) begin
    if (rd_en) rd_data <= mem[rd_addr];
  end

endmodule

// ===== hdl/dq_seq.sv =====
// Request sequencer: head/count/front/back registers and slot RAM access.
// Depends on dq_pkg and dq_ram.
`timescale 1ns / 1ps

module dq_seq
  import dq_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       req_fire,
  input  logic [2:0] req_code,
  input  elem_t      req_value,
  output res_t       res,
  output seq_stat_t  stat
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_WAIT = 1'b1;

  logic  state, state_next;
  addr_t head, head_next;
  cnt_t  cnt, cnt_next;
  elem_t front, front_next;
  elem_t back, back_next;
  elem_t popped_hold, popped_hold_next;
  logic  pend_front, pend_front_next;

  logic  wr_en, rd_en;
  addr_t wr_addr, rd_addr;
  elem_t rd_data;
  elem_t popped;
  logic [1:0] err;

  dq_ram #(
    .DATA_W (ELEM_WIDTH),
    .WORDS  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (req_value),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Request decode; pops that leave elements behind fetch the new end slot
  always_comb begin
    state_next       = state;
    head_next        = head;
    cnt_next         = cnt;
    front_next       = front;
    back_next        = back;
    popped_hold_next = popped_hold;
    pend_front_next  = pend_front;
    wr_en            = 1'b0;
    wr_addr          = head;
    rd_en            = 1'b0;
    rd_addr          = head;
    popped           = '0;
    err              = ERR_OK;

    unique case (state)
      ST_IDLE: begin
        if (req_fire) begin
          case (req_code)
            REQ_PUSH_FRONT: begin
              if (cnt == cnt_t'(DEPTH)) begin
                err = ERR_PUSH_FULL;
              end else begin
                head_next  = wrap_dec(head);
                wr_en      = 1'b1;
                wr_addr    = head_next;
                front_next = req_value;
                if (cnt == '0) back_next = req_value;
                cnt_next   = cnt + cnt_t'(1);
              end
            end
            REQ_PUSH_BACK: begin
              if (cnt == cnt_t'(DEPTH)) begin
                err = ERR_PUSH_FULL;
              end else begin
                wr_en     = 1'b1;
                wr_addr   = wrap_add(head, cnt);
                back_next = req_value;
                if (cnt == '0) front_next = req_value;
                cnt_next  = cnt + cnt_t'(1);
              end
            end
            REQ_POP_FRONT: begin
              if (cnt == '0) begin
                err = ERR_POP_EMPTY;
              end else begin
                popped    = front;
                head_next = wrap_inc(head);
                cnt_next  = cnt - cnt_t'(1);
                if (cnt > cnt_t'(1)) begin
                  rd_en            = 1'b1;
                  rd_addr          = wrap_inc(head);
                  pend_front_next  = 1'b1;
                  popped_hold_next = front;
                  state_next       = ST_WAIT;
                end
              end
            end
            REQ_POP_BACK: begin
              if (cnt == '0) begin
                err = ERR_POP_EMPTY;
              end else begin
                popped   = back;
                cnt_next = cnt - cnt_t'(1);
                if (cnt > cnt_t'(1)) begin
                  rd_en            = 1'b1;
                  rd_addr          = wrap_add(head, cnt - cnt_t'(2));
                  pend_front_next  = 1'b0;
                  popped_hold_next = back;
                  state_next       = ST_WAIT;
                end
              end
            end
            default: begin
              // status only, unused codes included
            end
          endcase
        end
      end
      ST_WAIT: begin
        if (pend_front) front_next = rd_data;
        else            back_next  = rd_data;
        popped     = popped_hold;
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Result assembly from the post-request state
  always_comb begin
    res.popped    = popped;
    res.count     = cnt_next;
    res.err       = err;
    res.front     = (cnt_next == '0) ? '0 : front_next;
    res.back      = (cnt_next == '0) ? '0 : back_next;
    stat.busy     = (state == ST_WAIT);
    stat.res_load = ((state == ST_IDLE) && req_fire && (state_next == ST_IDLE))
                    || (state == ST_WAIT);
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      head  <= '0;
      cnt   <= '0;
    end else begin
      state <= state_next;
      head  <= head_next;
      cnt   <= cnt_next;
    end
  end

  // End-element cache and pop bookkeeping
  always_ff @(posedge clk) begin
    front       <= front_next;
    back        <= back_next;
    popped_hold <= popped_hold_next;
    pend_front  <= pend_front_next;
  end

endmodule

// ===== hdl/double_ended_queue_top.sv =====
// Top level of the double-ended queue: handshake and result register.
// Depends on dq_pkg and dq_seq (which holds dq_ram).
`timescale 1ns / 1ps

// Bounded deque of DEPTH signed elements kept in a ring of RAM slots.
// Input channel (in_valid/in_ready): req_type selects push front, push back,
// pop front, pop back or status; push_value is stored on pushes.
// Output channel (out_valid/out_ready): exactly one result per request with
// the popped element, new front and back elements, count, empty flag and
// error code (pop on empty or push on full leaves the state untouched).
// Pushes, status requests, rejected requests and pops that empty the deque
// deliver their result in the cycle after acceptance, and a new request can be
// accepted every cycle while the receiver keeps up. A pop that leaves elements
// behind reads the new end element from the registered slot RAM port, so its
// result is loaded from a wait state and the input is held off during it.
// Front and back elements are cached in registers; the RAM read port is the
// only path a pop waits on.
// Reset (synchronous, active high) empties the deque and drops any pending
// result; slot contents are not cleared since only written slots are read.
// When the receiver stalls the result stays in the output register and
// in_ready drops until it is taken; the next request is accepted in the
// same cycle a result is taken.

module double_ended_queue_top
  import dq_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [2:0]            req_type,
  input  logic signed [ELEM_WIDTH-1:0] push_value,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic signed [ELEM_WIDTH-1:0] popped_value,
  output logic signed [ELEM_WIDTH-1:0] front_value,
  output logic signed [ELEM_WIDTH-1:0] back_value,
  output logic [CNT_W-1:0]      count,
  output logic                  is_empty,
  output logic [1:0]            error_code
);

  res_t      res;
  res_t      out_res;
  seq_stat_t stat;
  logic      in_fire;

  assign in_ready = !stat.busy && (!out_valid || out_ready);
  assign in_fire  = in_valid && in_ready;

  dq_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .req_fire  (in_fire),
    .req_code  (req_type),
    .req_value (push_value),
    .res       (res),
    .stat      (stat)
  );

  // Output valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (stat.res_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (stat.res_load) out_res <= res;
  end

  assign popped_value = out_res.popped;
  assign front_value  = out_res.front;
  assign back_value   = out_res.back;
  assign count        = out_res.count;
  assign is_empty     = (out_res.count == '0);
  assign error_code   = out_res.err;

  // A new result never lands on one that has not been taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    stat.res_load |-> (!out_valid || out_ready))
    else $error("result register overwritten");

  // Reported count never exceeds capacity
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (count <= CNT_W'(DEPTH)))
    else $error("count above depth");

  // A rejected pop reports no element
  a_pop_err_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (error_code == ERR_POP_EMPTY)) |-> (popped_value == '0))
    else $error("rejected pop carries data");

  // Each accepted request loads its result at once or enters the read wait state
  a_result_latency: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> ($past(stat.res_load) || stat.busy))
    else $error("request produced no result");

endmodule
